>>> rtl/voxel_face_culling_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel face culling block
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_ASSERT_SVH
`define VOXEL_FACE_CULLING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared widths, command codes, face bit positions and helpers of the voxel
// face culling block.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int CELL_SIDE_DEF   = 16;
    localparam int CELL_HEIGHT_DEF = 256;

    localparam int CMD_W    = 2;
    localparam int POS_XZ_W = 4;
    localparam int POS_Y_W  = 8;
    localparam int ID_W     = 8;
    localparam int MASK_W   = 6;
    localparam int COUNT_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CULL  = 2'd2
    } t_cmd;

    // Bit positions of the exposed-face mask.
    localparam int FACE_PZ = 0;
    localparam int FACE_NZ = 1;
    localparam int FACE_PX = 2;
    localparam int FACE_NX = 3;
    localparam int FACE_PY = 4;
    localparam int FACE_NY = 5;

    function automatic logic [COUNT_W-1:0] f_popcount(input logic [MASK_W-1:0] mask);
        logic [COUNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MASK_W; i++) begin
            cnt = cnt + COUNT_W'(mask[i]);
        end
        return cnt;
    endfunction

endpackage

>>> rtl/vfc_if.sv
// ----------------------------------------------------------------------------
// vfc_cmd_if and vfc_res_if
// Valid/ready channels that carry one command beat and one result beat.
// ----------------------------------------------------------------------------
interface vfc_cmd_if import vfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [POS_XZ_W-1:0] pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [POS_XZ_W-1:0] pos_z;
    logic [ID_W-1:0]     new_id;

    modport source (output valid, command, pos_x, pos_y, pos_z, new_id, input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, new_id, output ready);
endinterface

interface vfc_res_if import vfc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    cell_id;
    logic [MASK_W-1:0]  face_mask;
    logic [COUNT_W-1:0] face_count;

    modport source (output valid, cell_id, face_mask, face_count, input ready);
    modport sink   (input valid, cell_id, face_mask, face_count, output ready);
endinterface

>>> rtl/vfc_ram.sv
// ----------------------------------------------------------------------------
// vfc_ram
// Generic single-port RAM with one access per cycle and a registered read.
// ----------------------------------------------------------------------------
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/vfc_index_unit.sv
// ----------------------------------------------------------------------------
// vfc_index_unit
// Shared multiply-add by the chunk side, used twice to form a cell's linear
// store address from its height, x column and z column.
// ----------------------------------------------------------------------------
module vfc_index_unit import vfc_pkg::*; #(
    parameter int CELL_SIDE = CELL_SIDE_DEF,
    parameter int ADDR_W    = 16
) (
    input  logic [ADDR_W-1:0] i_acc,
    input  logic [ADDR_W-1:0] i_addend,
    output logic [ADDR_W-1:0] o_sum
);

    localparam int SIDE_W = $clog2(CELL_SIDE + 1);
    localparam int FULL_W = ADDR_W + SIDE_W;

    logic [FULL_W-1:0] w_full;

    // The product never exceeds the store depth when the cell lies in the
    // chunk, so dropping the top bits loses nothing that is used.
    assign w_full = FULL_W'(i_acc) * FULL_W'(CELL_SIDE) + FULL_W'(i_addend);
    assign o_sum  = w_full[ADDR_W-1:0];

endmodule

>>> rtl/voxel_face_culling.sv
// Sequence: after its beat is accepted, a write passes ST_IDX_ROW, ST_IDX_CELL, ST_WRITE
// and ST_DONE; a read or a cull passes ST_ACCESS and ST_DRAIN in place of ST_WRITE. One
// beat at a time: ready rises again once the result sits in the output register. A cull
// reads the single store port seven times. Reset: synchronous, active low; afterwards a
// clearing pass writes air to every cell, one per cycle, with ready low.
// ----------------------------------------------------------------------------
// voxel_face_culling
// Holds one chunk of 8-bit block ids in a single-port RAM and answers write,
// read and cull commands. A cull reads the cell and its six neighbors one
// after another and reports which faces touch air or the chunk boundary.
// ----------------------------------------------------------------------------
module voxel_face_culling import vfc_pkg::*; #(
    parameter int CELL_SIDE   = CELL_SIDE_DEF,
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfc_cmd_if.sink   i_cmd,
    vfc_res_if.source o_res
);

    // Linear address is (y * CELL_SIDE + x) * CELL_SIDE + z, so a step in z is
    // one entry, a step in x is one row and a step in y is one layer.
    localparam int DEPTH  = CELL_SIDE * CELL_SIDE * CELL_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] STEP_Z    = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] STEP_X    = ADDR_W'(CELL_SIDE);
    localparam logic [ADDR_W-1:0] STEP_Y    = ADDR_W'(CELL_SIDE * CELL_SIDE);

    // Read sequence: step 0 is the cell itself, steps 1 to 6 are the
    // neighbors in face-mask order.
    localparam logic [2:0] STEP_CELL = 3'd0;
    localparam logic [2:0] STEP_LAST = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IDX_ROW,
        ST_IDX_CELL,
        ST_WRITE,
        ST_ACCESS,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    // Captured command beat.
    logic [CMD_W-1:0]    r_cmd;
    logic [POS_XZ_W-1:0] r_x;
    logic [POS_Y_W-1:0]  r_y;
    logic [POS_XZ_W-1:0] r_z;
    logic [ID_W-1:0]     r_id;
    logic [MASK_W-1:0]   r_nb_in;

    // Address generation and read tracking.
    logic [ADDR_W-1:0] r_acc;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [2:0]        r_step;
    logic              r_cap_valid;
    logic [2:0]        r_cap_idx;

    // Collected answer.
    logic [ID_W-1:0]   r_cell;
    logic [MASK_W-1:0] r_mask;

    // Output register.
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_cell;
    logic [MASK_W-1:0]  r_out_mask;
    logic [COUNT_W-1:0] r_out_count;

    logic              w_in_beat;
    logic              w_inside;
    logic [MASK_W-1:0] w_nb_in;
    logic              w_cmd_known;
    logic              w_out_free;
    logic [ADDR_W-1:0] w_idx_acc;
    logic [ADDR_W-1:0] w_idx_add;
    logic [ADDR_W-1:0] w_idx_sum;
    logic [ADDR_W-1:0] w_nb_addr;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [ID_W-1:0]   w_ram_wdata;
    logic [ID_W-1:0]   w_ram_rdata;
    logic [MASK_W-1:0] w_final_mask;

    assign w_in_beat  = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    // Chunk bounds of the cell and of each neighbor, decided on the raw beat.
    assign w_inside = (32'(i_cmd.pos_x) < 32'(CELL_SIDE))
                   && (32'(i_cmd.pos_z) < 32'(CELL_SIDE))
                   && (32'(i_cmd.pos_y) < 32'(CELL_HEIGHT));

    assign w_nb_in[FACE_PZ] = (32'(i_cmd.pos_z) + 32'd1) < 32'(CELL_SIDE);
    assign w_nb_in[FACE_NZ] = i_cmd.pos_z != '0;
    assign w_nb_in[FACE_PX] = (32'(i_cmd.pos_x) + 32'd1) < 32'(CELL_SIDE);
    assign w_nb_in[FACE_NX] = i_cmd.pos_x != '0;
    assign w_nb_in[FACE_PY] = (32'(i_cmd.pos_y) + 32'd1) < 32'(CELL_HEIGHT);
    assign w_nb_in[FACE_NY] = i_cmd.pos_y != '0;

    assign w_cmd_known = (i_cmd.command == CMD_WRITE) || (i_cmd.command == CMD_READ)
                      || (i_cmd.command == CMD_CULL);

    // The index unit first forms the row y*SIDE + x, then the cell row*SIDE + z.
    always_comb begin
        if (r_state == ST_IDX_ROW) begin
            w_idx_acc = ADDR_W'(r_y);
            w_idx_add = ADDR_W'(r_x);
        end else begin
            w_idx_acc = r_acc;
            w_idx_add = ADDR_W'(r_z);
        end
    end

    vfc_index_unit #(
        .CELL_SIDE (CELL_SIDE),
        .ADDR_W    (ADDR_W)
    ) u_index (
        .i_acc    (w_idx_acc),
        .i_addend (w_idx_add),
        .o_sum    (w_idx_sum)
    );

    // Neighbor addresses. A neighbor outside the chunk may wrap to any
    // address; its data is ignored because its bound bit is clear.
    always_comb begin
        unique case (r_step)
            3'd1:    w_nb_addr = r_base + STEP_Z;
            3'd2:    w_nb_addr = r_base - STEP_Z;
            3'd3:    w_nb_addr = r_base + STEP_X;
            3'd4:    w_nb_addr = r_base - STEP_X;
            3'd5:    w_nb_addr = r_base + STEP_Y;
            3'd6:    w_nb_addr = r_base - STEP_Y;
            default: w_nb_addr = r_base;
        endcase
    end

    // Store port: the clearing pass and writes use it for writing, the
    // access sequence for reading.
    always_comb begin
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_WRITE: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_base;
                w_ram_wdata = r_id;
            end
            default: begin
                w_ram_we    = 1'b0;
                w_ram_addr  = w_nb_addr;
                w_ram_wdata = r_id;
            end
        endcase
    end

    vfc_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Faces count only for a cull of a solid cell.
    assign w_final_mask = ((r_cmd == CMD_CULL) && (r_cell != '0)) ? r_mask : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = (w_inside && w_cmd_known) ? ST_IDX_ROW : ST_DONE;
                end
            end
            ST_IDX_ROW: begin
                n_state = ST_IDX_CELL;
            end
            ST_IDX_CELL: begin
                n_state = (r_cmd == CMD_WRITE) ? ST_WRITE : ST_ACCESS;
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_ACCESS: begin
                if ((r_cmd == CMD_READ) || (r_step == STEP_LAST)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cap_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= STEP_CELL;
        end else begin
            r_state     <= n_state;
            r_cap_valid <= (r_state == ST_ACCESS);
            r_cap_idx   <= r_step;

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + STEP_Z;
            end

            if (w_in_beat) begin
                r_cmd   <= i_cmd.command;
                r_x     <= i_cmd.pos_x;
                r_y     <= i_cmd.pos_y;
                r_z     <= i_cmd.pos_z;
                r_id    <= i_cmd.new_id;
                r_nb_in <= w_nb_in;
                r_cell  <= '0;
                r_mask  <= '0;
                r_step  <= STEP_CELL;
            end

            if (r_state == ST_IDX_ROW) begin
                r_acc <= w_idx_sum;
            end
            if (r_state == ST_IDX_CELL) begin
                r_base <= w_idx_sum;
            end
            if (r_state == ST_WRITE) begin
                r_cell <= r_id;
            end
            if (r_state == ST_ACCESS) begin
                r_step <= r_step + 3'd1;
            end

            // Read data returns in the cycle after its address was issued.
            if (r_cap_valid) begin
                if (r_cap_idx == STEP_CELL) begin
                    r_cell <= w_ram_rdata;
                end else begin
                    r_mask[r_cap_idx - 3'd1] <= (w_ram_rdata == '0)
                                                || !r_nb_in[r_cap_idx - 3'd1];
                end
            end

            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_cell  <= r_cell;
                r_out_mask  <= w_final_mask;
                r_out_count <= f_popcount(w_final_mask);
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_cmd.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.cell_id    = r_out_cell;
    assign o_res.face_mask  = r_out_mask;
    assign o_res.face_count = r_out_count;

endmodule

>>> rtl/vfc_checker.sv
// ----------------------------------------------------------------------------
// vfc_checker
// Port-level checks of the voxel face culling block, bound to its top level.
// ----------------------------------------------------------------------------
`include "voxel_face_culling_assert.svh"

module vfc_checker import vfc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ID_W-1:0]    i_cell_id,
    input logic [MASK_W-1:0]  i_face_mask,
    input logic [COUNT_W-1:0] i_face_count
);

    logic w_in_beat;
    logic w_out_stall;

    assign w_in_beat   = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    // The count always matches the mask it travels with.
    `VFC_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, i_out_valid, i_face_count == f_popcount(i_face_mask), "face count differs from mask")
    // Only a solid cell can show exposed faces.
    `VFC_ASSERT_IMP(a_air_no_faces, i_clk, i_rst_n, i_out_valid && (i_face_mask != '0), i_cell_id != '0, "faces reported for air")
    // A command keeps the block busy, so ready drops once its beat is taken.
    `VFC_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, !i_in_ready, "ready right after a beat")
    // A stalled result beat stays offered.
    `VFC_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, w_out_stall, i_out_valid, "result dropped while stalled")

endmodule

bind voxel_face_culling vfc_checker u_vfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_cell_id    (o_res.cell_id),
    .i_face_mask  (o_res.face_mask),
    .i_face_count (o_res.face_count)
);
